// ----- rtl/pf6_pkg.sv -----
// Shared constants, types and codes for the 6x6 Playfair cipher block.
package pf6_pkg;

    localparam int SYM_W     = 6;
    localparam int RC_W      = 3;
    localparam int SIDE      = 6;
    localparam int CELLS     = 36;
    localparam int CFG_IDX_W = 1;

    localparam logic [SYM_W-1:0] FILLER_MAX   = SYM_W'(CELLS - 1);
    localparam logic [SYM_W-1:0] FILLER_RESET = SYM_W'(16);

    typedef struct packed {
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
    } t_coord;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENCIPHER = 1'b0,
        CFG_FILLER   = 1'b1
    } t_cfg_idx;

endpackage

// ----- rtl/pf6_if.sv -----
// Handshake channel interfaces for input symbols, output digraphs and configuration.
interface pf6_in_if;
    import pf6_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             last;
    modport source (output valid, mode, symbol, last, input ready);
    modport sink   (input valid, mode, symbol, last, output ready);
endinterface

interface pf6_out_if;
    import pf6_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] first_out;
    logic [SYM_W-1:0] second_out;
    logic             line_end;
    modport source (output valid, first_out, second_out, line_end, input ready);
    modport sink   (input valid, first_out, second_out, line_end, output ready);
endinterface

interface pf6_cfg_if;
    import pf6_pkg::*;
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [SYM_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pf6_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pf6_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pf6_cell_unit.sv -----
// Shared substitution unit: maps one symbol's square position to its output cell.
module pf6_cell_unit (
    input  pf6_pkg::t_coord               i_self,
    input  pf6_pkg::t_coord               i_other,
    input  logic                          i_encipher,
    output logic [pf6_pkg::SYM_W-1:0]     o_cell
);
    import pf6_pkg::*;

    localparam logic [RC_W-1:0] LAST_RC = RC_W'(SIDE - 1);

    logic [RC_W-1:0] w_row;
    logic [RC_W-1:0] w_col;

    function automatic logic [RC_W-1:0] wrap_step(input logic [RC_W-1:0] v, input logic up);
        logic [RC_W-1:0] res;
        if (up) begin
            res = (v == LAST_RC) ? '0 : v + RC_W'(1);
        end else begin
            res = (v == '0) ? LAST_RC : v - RC_W'(1);
        end
        return res;
    endfunction

    always_comb begin
        if (i_self.row == i_other.row) begin
            w_row = i_self.row;
            w_col = wrap_step(i_self.col, i_encipher);
        end else if (i_self.col == i_other.col) begin
            w_row = wrap_step(i_self.row, i_encipher);
            w_col = i_self.col;
        end else begin
            w_row = i_self.row;
            w_col = i_other.col;
        end
    end

    // Cell index is row * 6 + col, formed as row * 4 + row * 2 + col.
    assign o_cell = {1'b0, w_row, 2'b00} + {2'b00, w_row, 1'b0} + {3'b000, w_col};

endmodule

// ----- rtl/playfair_6x6_cipher_top.sv -----
// Top level of the 6x6 Playfair cipher: key square builder and digraph sequencer.
// A key item is taken in S_IDLE; a key item marked last adds a fill walk over all 36 symbols.
// A text item that completes one digraph passes S_RDA, S_RDB, S_CALC, S_KB, S_KDONE and
// S_PUSH, which waits for a free output; two digraphs run the walk twice. The single
// position and square RAM read ports set this walk. Reset clears control state and restores the
// registers to encipher and filler Q; the square RAMs are left uncleared.
module playfair_6x6_cipher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pf6_in_if.sink     i_in,
    pf6_out_if.source  o_out,
    pf6_cfg_if.sink    i_cfg
);
    import pf6_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FILL  = 8'b00000010,
        S_RDA   = 8'b00000100,
        S_RDB   = 8'b00001000,
        S_CALC  = 8'b00010000,
        S_KB    = 8'b00100000,
        S_KDONE = 8'b01000000,
        S_PUSH  = 8'b10000000
    } t_state;

    localparam logic [SYM_W-1:0] CELLS_V = SYM_W'(CELLS);
    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(CELLS - 1);
    localparam logic [RC_W-1:0]  LAST_RC = RC_W'(SIDE - 1);

    t_state             r_state, n_state;
    logic               r_encipher, n_encipher;
    logic [SYM_W-1:0]   r_filler, n_filler;
    logic [CELLS-1:0]   r_seen, n_seen;
    logic [SYM_W-1:0]   r_fill_count, n_fill_count;
    t_coord             r_fill_pos, n_fill_pos;
    logic [SYM_W-1:0]   r_fill_sym, n_fill_sym;
    logic               r_square_ready, n_square_ready;
    logic [SYM_W-1:0]   r_held_sym, n_held_sym;
    logic               r_held_valid, n_held_valid;
    logic [SYM_W-1:0]   r_a, n_a;
    logic [SYM_W-1:0]   r_b, n_b;
    logic               r_end, n_end;
    logic               r_two, n_two;
    t_coord             r_pa, n_pa;
    t_coord             r_pb, n_pb;
    logic [SYM_W-1:0]   r_oa, n_oa;
    logic [SYM_W-1:0]   r_ob, n_ob;
    logic               r_out_valid, n_out_valid;
    logic [SYM_W-1:0]   r_out_first, n_out_first;
    logic [SYM_W-1:0]   r_out_second, n_out_second;
    logic               r_out_end, n_out_end;

    logic               w_in_xfer;
    logic               w_sym_ok;
    logic [SYM_W-1:0]   w_filler;
    logic [CELLS-1:0]   w_seen_base;
    logic [SYM_W-1:0]   w_count_base;
    t_coord             w_pos_base;
    logic               w_place;
    logic [SYM_W-1:0]   w_place_sym;
    logic [SYM_W-1:0]   w_pos_raddr;
    logic [SYM_W-1:0]   w_pos_rdata;
    t_coord             w_pos_rd;
    t_coord             w_unit_self;
    t_coord             w_unit_other;
    logic [SYM_W-1:0]   w_cell;
    logic [SYM_W-1:0]   w_key_rdata;
    logic               w_out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_sym_ok    = (i_in.symbol < CELLS_V);
    assign w_filler    = (r_filler > FILLER_MAX) ? FILLER_MAX : r_filler;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_pos_rd    = w_pos_rdata;

    assign o_out.valid      = r_out_valid;
    assign o_out.first_out  = r_out_first;
    assign o_out.second_out = r_out_second;
    assign o_out.line_end   = r_out_end;

    // A new key starts from an empty square when the previous one is complete.
    always_comb begin
        if (r_state == S_IDLE && r_square_ready) begin
            w_seen_base  = '0;
            w_count_base = '0;
            w_pos_base   = '0;
        end else begin
            w_seen_base  = r_seen;
            w_count_base = r_fill_count;
            w_pos_base   = r_fill_pos;
        end
        if (r_state == S_FILL) begin
            w_place_sym = r_fill_sym;
            w_place     = !r_seen[r_fill_sym] && (r_fill_count < CELLS_V);
        end else begin
            w_place_sym = i_in.symbol;
            w_place     = w_in_xfer && !i_in.mode && w_sym_ok &&
                          !w_seen_base[i_in.symbol] && (w_count_base < CELLS_V);
        end
    end

    assign w_pos_raddr  = (r_state == S_RDA) ? r_a : r_b;
    assign w_unit_self  = (r_state == S_CALC) ? r_pa : r_pb;
    assign w_unit_other = (r_state == S_CALC) ? w_pos_rd : r_pa;

    pf6_ram #(.WIDTH(SYM_W), .DEPTH(CELLS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_place),
        .i_waddr (w_count_base),
        .i_wdata (w_place_sym),
        .i_raddr (w_cell),
        .o_rdata (w_key_rdata)
    );

    pf6_ram #(.WIDTH(SYM_W), .DEPTH(CELLS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_place),
        .i_waddr (w_place_sym),
        .i_wdata (w_pos_base),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    pf6_cell_unit u_cell_unit (
        .i_self     (w_unit_self),
        .i_other    (w_unit_other),
        .i_encipher (r_encipher),
        .o_cell     (w_cell)
    );

    always_comb begin
        n_state        = r_state;
        n_encipher     = r_encipher;
        n_filler       = r_filler;
        n_seen         = r_seen;
        n_fill_count   = r_fill_count;
        n_fill_pos     = r_fill_pos;
        n_fill_sym     = r_fill_sym;
        n_square_ready = r_square_ready;
        n_held_sym     = r_held_sym;
        n_held_valid   = r_held_valid;
        n_a            = r_a;
        n_b            = r_b;
        n_end          = r_end;
        n_two          = r_two;
        n_pa           = r_pa;
        n_pb           = r_pb;
        n_oa           = r_oa;
        n_ob           = r_ob;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_first    = r_out_first;
        n_out_second   = r_out_second;
        n_out_end      = r_out_end;

        if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_ENCIPHER: n_encipher = i_cfg.data[0];
                CFG_FILLER:   n_filler   = i_cfg.data;
                default:      n_filler   = r_filler;
            endcase
        end

        if (w_place) begin
            n_seen                = w_seen_base;
            n_seen[w_place_sym]   = 1'b1;
            n_fill_count          = w_count_base + SYM_W'(1);
            if (w_pos_base.col == LAST_RC) begin
                n_fill_pos.col = '0;
                n_fill_pos.row = w_pos_base.row + RC_W'(1);
            end else begin
                n_fill_pos.col = w_pos_base.col + RC_W'(1);
                n_fill_pos.row = w_pos_base.row;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && !i_in.mode) begin
                    if (r_square_ready) begin
                        n_square_ready = 1'b0;
                        n_held_valid   = 1'b0;
                        if (!w_place) begin
                            n_seen       = w_seen_base;
                            n_fill_count = w_count_base;
                            n_fill_pos   = w_pos_base;
                        end
                    end
                    if (w_place) begin
                        n_seen              = w_seen_base;
                        n_seen[i_in.symbol] = 1'b1;
                    end
                    if (i_in.last) begin
                        n_fill_sym = '0;
                        n_state    = S_FILL;
                    end
                end else if (w_in_xfer && r_square_ready) begin
                    n_two = 1'b0;
                    n_b   = w_filler;
                    if (w_sym_ok) begin
                        if (!r_held_valid) begin
                            n_held_sym   = i_in.symbol;
                            n_held_valid = !i_in.last;
                            n_a          = i_in.symbol;
                            n_end        = 1'b1;
                            if (i_in.last) begin
                                n_state = S_RDA;
                            end
                        end else if (i_in.symbol == r_held_sym) begin
                            n_a          = r_held_sym;
                            n_end        = 1'b0;
                            n_two        = i_in.last;
                            n_held_valid = !i_in.last;
                            n_state      = S_RDA;
                        end else begin
                            n_a          = r_held_sym;
                            n_b          = i_in.symbol;
                            n_end        = i_in.last;
                            n_held_valid = 1'b0;
                            n_state      = S_RDA;
                        end
                    end else if (i_in.last && r_held_valid) begin
                        n_a          = r_held_sym;
                        n_end        = 1'b1;
                        n_held_valid = 1'b0;
                        n_state      = S_RDA;
                    end
                end
            end
            S_FILL: begin
                n_fill_sym = r_fill_sym + SYM_W'(1);
                if (r_fill_sym == LAST_SYM) begin
                    n_square_ready = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: begin
                n_pa    = w_pos_rd;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_pb    = w_pos_rd;
                n_state = S_KB;
            end
            S_KB: begin
                n_oa    = w_key_rdata;
                n_state = S_KDONE;
            end
            S_KDONE: begin
                n_ob    = w_key_rdata;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_first  = r_oa;
                    n_out_second = r_ob;
                    n_out_end    = r_end;
                    if (r_two) begin
                        n_two   = 1'b0;
                        n_b     = w_filler;
                        n_end   = 1'b1;
                        n_state = S_RDA;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_encipher     <= 1'b1;
            r_filler       <= FILLER_RESET;
            r_seen         <= '0;
            r_fill_count   <= '0;
            r_fill_pos     <= '0;
            r_fill_sym     <= '0;
            r_square_ready <= 1'b0;
            r_held_sym     <= '0;
            r_held_valid   <= 1'b0;
            r_two          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_encipher     <= n_encipher;
            r_filler       <= n_filler;
            r_seen         <= n_seen;
            r_fill_count   <= n_fill_count;
            r_fill_pos     <= n_fill_pos;
            r_fill_sym     <= n_fill_sym;
            r_square_ready <= n_square_ready;
            r_held_sym     <= n_held_sym;
            r_held_valid   <= n_held_valid;
            r_two          <= n_two;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_b          <= n_b;
        r_end        <= n_end;
        r_pa         <= n_pa;
        r_pb         <= n_pb;
        r_oa         <= n_oa;
        r_ob         <= n_ob;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_end    <= n_out_end;
    end

    // Every placed symbol is marked seen exactly once.
    a_seen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_seen) == 32'(r_fill_count))
        else $error("seen map and fill count disagree");

    // A complete square holds all 36 symbols.
    a_square_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_square_ready |-> (r_fill_count == CELLS_V))
        else $error("square marked ready before it is full");

    // A text symbol is only held while the square is complete.
    a_held_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> r_square_ready)
        else $error("held text symbol without a complete square");

endmodule

// ----- test/tb_pf6_digraph_checker.sv -----
// Checker that predicts the cipher digraphs from observed transfers and compares the outputs.
`timescale 1ns / 100ps
module tb_pf6_digraph_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pf6_in_if    i_in,
    pf6_out_if   i_out,
    pf6_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import pf6_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] first_sym;
        logic [SYM_W-1:0] second_sym;
        logic             line_end;
    } t_digraph;

    t_digraph         digraph_q[$];
    logic [SYM_W-1:0] square [CELLS];
    logic [SYM_W-1:0] cell_of [CELLS];
    logic [CELLS-1:0] used_syms;
    int               cells_filled;
    bit               square_done;
    logic [SYM_W-1:0] held_sym;
    bit               held_ok;
    bit               enc_mode;
    logic [SYM_W-1:0] filler_reg;
    int               mismatch_count = 0;
    int               waiting_count = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = waiting_count;

    task automatic new_square();
        used_syms    = '0;
        cells_filled = 0;
        square_done  = 1'b0;
        held_sym     = '0;
        held_ok      = 1'b0;
    endtask

    task automatic add_symbol(logic [SYM_W-1:0] s);
        if (cells_filled < CELLS) begin
            square[cells_filled] = s;
            cell_of[s] = SYM_W'(cells_filled);
            used_syms[s] = 1'b1;
            cells_filled++;
        end
    endtask

    function automatic t_digraph substitute(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b,
                                            bit at_end);
        int       ra, ca, rb, cb, shift, na, nb;
        t_digraph d;
        ra = int'(cell_of[a]) / SIDE;
        ca = int'(cell_of[a]) % SIDE;
        rb = int'(cell_of[b]) / SIDE;
        cb = int'(cell_of[b]) % SIDE;
        shift = enc_mode ? 1 : SIDE - 1;
        if (ra == rb) begin
            na = ra * SIDE + (ca + shift) % SIDE;
            nb = rb * SIDE + (cb + shift) % SIDE;
        end else if (ca == cb) begin
            na = ((ra + shift) % SIDE) * SIDE + ca;
            nb = ((rb + shift) % SIDE) * SIDE + cb;
        end else begin
            na = ra * SIDE + cb;
            nb = rb * SIDE + ca;
        end
        d.first_sym  = square[na];
        d.second_sym = square[nb];
        d.line_end   = at_end;
        return d;
    endfunction

    task automatic cipher_step(bit is_text, logic [SYM_W-1:0] s, bit is_last);
        bit               sym_ok;
        logic [SYM_W-1:0] pad;
        sym_ok = s < CELLS;
        pad = (filler_reg > FILLER_MAX) ? FILLER_MAX : filler_reg;
        if (!is_text) begin
            if (square_done)
                new_square();
            if (sym_ok && !used_syms[s])
                add_symbol(s);
            if (is_last) begin
                for (int c = 0; c < CELLS; c++)
                    if (!used_syms[c])
                        add_symbol(SYM_W'(c));
                square_done = 1'b1;
            end
        end else if (square_done) begin
            if (sym_ok) begin
                if (!held_ok) begin
                    held_sym = s;
                    held_ok  = 1'b1;
                end else if (s == held_sym) begin
                    digraph_q.push_back(substitute(held_sym, pad, 1'b0));
                end else begin
                    digraph_q.push_back(substitute(held_sym, s, is_last));
                    held_ok = 1'b0;
                end
            end
            if (is_last && held_ok) begin
                digraph_q.push_back(substitute(held_sym, pad, 1'b1));
                held_ok = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_digraph want;
        t_digraph got;
        if (!i_rst_n) begin
            new_square();
            enc_mode   = 1'b1;
            filler_reg = FILLER_RESET;
            digraph_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.first_sym  = i_out.first_out;
                got.second_sym = i_out.second_out;
                got.line_end   = i_out.line_end;
                if (digraph_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected digraph %0d %0d end %0b", $time,
                                 got.first_sym, got.second_sym, got.line_end);
                end else begin
                    want = digraph_q.pop_front();
                    if (got.first_sym !== want.first_sym ||
                        got.second_sym !== want.second_sym ||
                        got.line_end !== want.line_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: digraph mismatch, expected %0d %0d end %0b,",
                                      " got %0d %0d end %0b"},
                                     $time, want.first_sym, want.second_sym, want.line_end,
                                     got.first_sym, got.second_sym, got.line_end);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ENCIPHER: begin
                        enc_mode = i_cfg.data[0];
                    end
                    CFG_FILLER: begin
                        filler_reg = i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in.valid && i_in.ready)
                cipher_step(i_in.mode, i_in.symbol, i_in.last);
        end
        waiting_count = digraph_q.size();
    end

endmodule

// ----- test/tb_playfair_6x6_cipher_top.sv -----
// Testbench top for the 6x6 Playfair cipher: drives symbols, register writes and output stalls.
`timescale 1ns / 100ps
module tb_playfair_6x6_cipher_top;
    import pf6_pkg::*;

    localparam bit               MODE_KEY      = 1'b0;
    localparam bit               MODE_TEXT     = 1'b1;
    localparam logic [SYM_W-1:0] SYM_TOP       = {SYM_W{1'b1}};
    localparam int               SETTLE_CYCLES = 60;
    localparam int               HOLD_CYCLES   = 400;
    localparam int               PHASE_ITEMS   = 290;
    localparam int               CYCLE_LIMIT   = 1_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    int               cycle_count = 0;
    int               fail_count;
    int               expect_count;
    bit               gaps_on;
    bit               hold_req = 1'b0;
    bit               key_live = 1'b0;
    int               useful_items = 0;
    logic [SYM_W-1:0] pad_now = FILLER_RESET;

    pf6_in_if  in_ch ();
    pf6_out_if out_ch ();
    pf6_cfg_if cfg_ch ();

    playfair_6x6_cipher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tb_pf6_digraph_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (fail_count),
        .o_pending (expect_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int run_left;
        bit level;
        run_left = 0;
        level = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                level = 1'b0;
                run_left = HOLD_CYCLES;
            end else if (run_left == 0) begin
                level = !level;
                if (level)
                    run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                           : $urandom_range(1, 8);
                else
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                           : $urandom_range(1, 3);
            end
            run_left--;
            out_ch.ready <= level;
        end
    end

    function automatic logic [SYM_W-1:0] pick_symbol(int bad_pct);
        if ($urandom_range(0, 99) < bad_pct)
            return SYM_W'($urandom_range(CELLS, SYM_TOP));
        return SYM_W'($urandom_range(0, CELLS - 1));
    endfunction

    task automatic send_symbol(bit mode, logic [SYM_W-1:0] sym, bit last);
        int gap;
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= mode;
        in_ch.symbol <= sym;
        in_ch.last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        if (mode == MODE_KEY) begin
            key_live = last;
            useful_items++;
        end else if (key_live) begin
            useful_items++;
        end
        if (gaps_on && $urandom_range(0, 9) < 3) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [SYM_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expect_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int quota);
        int               start;
        int               n_key;
        int               n_text;
        int               pick;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] prev;
        start = useful_items;
        while (useful_items - start < quota) begin
            if ($urandom_range(0, 99) < 12) begin
                send_symbol(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, SYM_TOP)),
                            1'($urandom_range(0, 1)));
            end else begin
                if (!key_live || $urandom_range(0, 4) == 0) begin
                    n_key = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
                                                        : $urandom_range(0, 10);
                    for (int k = 0; k < n_key; k++)
                        send_symbol(MODE_KEY, pick_symbol(10), 1'b0);
                    send_symbol(MODE_KEY, pick_symbol(30), 1'b1);
                end
                for (int ln = $urandom_range(1, 4); ln > 0; ln--) begin
                    n_text = $urandom_range(1, 14);
                    prev = pick_symbol(0);
                    for (int t = 0; t < n_text; t++) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 20)
                            sym = prev;
                        else if (pick < 25)
                            sym = pick_symbol(100);
                        else if (pick < 30)
                            sym = pad_now;
                        else
                            sym = pick_symbol(0);
                        send_symbol(MODE_TEXT, sym, t == n_text - 1);
                        prev = sym;
                    end
                end
            end
        end
    endtask

    initial begin
        bit               enc_list [6];
        logic [SYM_W-1:0] fill_list [6];
        enc_list  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        fill_list = '{FILLER_RESET, '0, FILLER_MAX, SYM_TOP,
                      SYM_W'($urandom_range(0, CELLS - 1)),
                      SYM_W'($urandom_range(0, CELLS - 1))};
        in_ch.valid  <= 1'b0;
        in_ch.mode   <= MODE_KEY;
        in_ch.symbol <= '0;
        in_ch.last   <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_ENCIPHER;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Text before any key is dropped; the key repeats a symbol and carries an
        // out-of-range code before its last transfer completes the square.
        gaps_on = 1'b1;
        send_symbol(MODE_TEXT, 6'd7, 1'b0);
        send_symbol(MODE_KEY, 6'd9, 1'b0);
        send_symbol(MODE_KEY, 6'd9, 1'b0);
        send_symbol(MODE_KEY, 6'd50, 1'b0);
        send_symbol(MODE_KEY, 6'd2, 1'b1);
        send_symbol(MODE_TEXT, 6'd5, 1'b0);
        send_symbol(MODE_TEXT, 6'd8, 1'b0);
        send_symbol(MODE_TEXT, 6'd11, 1'b0);
        send_symbol(MODE_TEXT, 6'd5, 1'b0);
        send_symbol(MODE_TEXT, 6'd12, 1'b0);
        send_symbol(MODE_TEXT, 6'd30, 1'b0);
        send_symbol(MODE_TEXT, 6'd13, 1'b0);
        send_symbol(MODE_TEXT, 6'd26, 1'b0);
        send_symbol(MODE_TEXT, 6'd20, 1'b0);
        send_symbol(MODE_TEXT, 6'd20, 1'b0);
        send_symbol(MODE_TEXT, 6'd21, 1'b1);
        send_symbol(MODE_TEXT, 6'd22, 1'b0);
        send_symbol(MODE_TEXT, 6'd22, 1'b1);
        send_symbol(MODE_TEXT, 6'd23, 1'b1);
        send_symbol(MODE_TEXT, SYM_TOP, 1'b1);
        send_symbol(MODE_TEXT, 6'd24, 1'b0);
        send_symbol(MODE_TEXT, 6'd40, 1'b1);
        send_symbol(MODE_TEXT, FILLER_RESET, 1'b0);
        send_symbol(MODE_TEXT, FILLER_RESET, 1'b1);
        settle();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_ENCIPHER, SYM_W'(enc_list[p]));
            write_reg(CFG_FILLER, fill_list[p]);
            pad_now = (fill_list[p] > FILLER_MAX) ? FILLER_MAX : fill_list[p];
            gaps_on = (p != 2);
            if (p == 1)
                hold_req = 1'b1;
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0 && expect_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
